// ----- rtl/pip_pkg.sv -----
// Shared constants for the point-in-polygon crossing test.
`default_nettype none

package pip_pkg;

  // Default coordinate width, two's complement.
  localparam int unsigned CoordBitsDef = 16;

  // Width of the result stream payload in bits (one byte).
  localparam int unsigned OutDataBits = 8;

endpackage : pip_pkg

`default_nettype wire

// ----- rtl/pip_edge_test.sv -----
// Exact ray-crossing test of one polygon edge against a horizontal ray towards +x.
`default_nettype none

module pip_edge_test
  import pip_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] xi_i,
  input  logic signed [COORD_BITS-1:0] yi_i,
  input  logic signed [COORD_BITS-1:0] xj_i,
  input  logic signed [COORD_BITS-1:0] yj_i,
  output logic                         cross_o
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  logic signed [DiffBits-1:0] dy;
  logic signed [DiffBits-1:0] dpx;
  logic signed [DiffBits-1:0] dex;
  logic signed [DiffBits-1:0] dpy;
  logic signed [ProdBits-1:0] lhs;
  logic signed [ProdBits-1:0] rhs;
  logic                       straddle;

  // Form the differences one bit wider so none can wrap
  assign dy  = $signed({yj_i[COORD_BITS-1], yj_i}) - $signed({yi_i[COORD_BITS-1], yi_i});
  assign dpx = $signed({px_i[COORD_BITS-1], px_i}) - $signed({xi_i[COORD_BITS-1], xi_i});
  assign dex = $signed({xj_i[COORD_BITS-1], xj_i}) - $signed({xi_i[COORD_BITS-1], xi_i});
  assign dpy = $signed({py_i[COORD_BITS-1], py_i}) - $signed({yi_i[COORD_BITS-1], yi_i});

  // Cross-multiply instead of dividing by dy; the products are exact
  assign lhs = dpx * dy;
  assign rhs = dex * dpy;

  // The edge counts only if its ends lie on opposite sides of the ray
  assign straddle = (yi_i > py_i) != (yj_i > py_i);

  // The sign of dy sets the direction of the comparison
  always_comb begin
    if (!straddle) begin
      cross_o = 1'b0;
    end else if (dy > 0) begin
      cross_o = lhs < rhs;
    end else begin
      cross_o = rhs < lhs;
    end
  end

endmodule : pip_edge_test

`default_nettype wire

// ----- rtl/point_in_polygon_crossing_test.sv -----
// Top level of the streamed even-odd point-in-polygon test.
`default_nettype none

// Even-odd point-in-polygon test on a polygon that arrives one vertex per
// transfer. The first vertex transfer of each polygon also carries the test
// point, which is held until the polygon closes; on later transfers the test
// point fields are ignored. Later transfers test the edge from the previous
// vertex, and the transfer with tlast set also tests the closing edge back to
// the first vertex, checks the point against the inclusive bounding box of
// the vertices and sends one result byte (bit 0 = inside). Each vertex passes
// an input register, then both edge tests (two multipliers each, one compare)
// and the box compare run in parallel into the state and result registers, so
// a new vertex is taken every cycle while the result side keeps up. A result
// passes the input register and then the result register; a closing vertex
// waits in the input register while the result register is still full.
// Coordinates are COORD_BITS-bit two's complement values.
module point_in_polygon_crossing_test
  import pip_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Vertex stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, low bit up: test_x, test_y, vertex_x, vertex_y, zero fill to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tlast: last_vertex
  input  logic                       s_axis_tlast,
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata, low bit up: inside_res, zero fill
  output logic [OutDataBits-1:0]     m_axis_tdata
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Input register
  logic   in_valid_q;
  coord_t tx_q, ty_q, vx_q, vy_q;
  logic   last_q;

  // Polygon state
  logic   mid_q;
  logic   par_q;
  coord_t hx_q, hy_q, fx_q, fy_q, pvx_q, pvy_q;
  coord_t minx_q, maxx_q, miny_q, maxy_q;

  // Result register
  logic   out_valid_q;
  logic   inside_q;

  logic   out_free;
  logic   advance;
  coord_t pt_x, pt_y, f_x, f_y;
  coord_t minx_d, maxx_d, miny_d, maxy_d;
  logic   edge_cross, close_cross;
  logic   par_d, par_fin, in_box;

  // Handshake: only a closing vertex waits for room in the result register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  // Capture the incoming vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tx_q   <= s_axis_tdata[COORD_BITS-1:0];
      ty_q   <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      vx_q   <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      vy_q   <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
      last_q <= s_axis_tlast;
    end
  end

  // Pick the test point and first vertex, fresh on the first vertex
  assign pt_x = mid_q ? hx_q : tx_q;
  assign pt_y = mid_q ? hy_q : ty_q;
  assign f_x  = mid_q ? fx_q : vx_q;
  assign f_y  = mid_q ? fy_q : vy_q;

  // Edge from the previous vertex to this one
  pip_edge_test #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .px_i   (hx_q),
    .py_i   (hy_q),
    .xi_i   (vx_q),
    .yi_i   (vy_q),
    .xj_i   (pvx_q),
    .yj_i   (pvy_q),
    .cross_o(edge_cross)
  );

  // Closing edge from the first vertex to this one
  pip_edge_test #(
    .COORD_BITS(COORD_BITS)
  ) u_close (
    .px_i   (pt_x),
    .py_i   (pt_y),
    .xi_i   (f_x),
    .yi_i   (f_y),
    .xj_i   (vx_q),
    .yj_i   (vy_q),
    .cross_o(close_cross)
  );

  // Advance parity and bounding box
  always_comb begin
    par_d   = mid_q && (par_q ^ edge_cross);
    par_fin = par_d ^ close_cross;
    if (mid_q) begin
      minx_d = (vx_q < minx_q) ? vx_q : minx_q;
      maxx_d = (vx_q > maxx_q) ? vx_q : maxx_q;
      miny_d = (vy_q < miny_q) ? vy_q : miny_q;
      maxy_d = (vy_q > maxy_q) ? vy_q : maxy_q;
    end else begin
      minx_d = vx_q;
      maxx_d = vx_q;
      miny_d = vy_q;
      maxy_d = vy_q;
    end
    in_box = (pt_x >= minx_d) && (pt_x <= maxx_d) &&
             (pt_y >= miny_d) && (pt_y <= maxy_d);
  end

  // Hold polygon control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      par_q <= 1'b0;
    end else if (advance) begin
      mid_q <= !last_q;
      par_q <= par_d;
    end
  end

  // Hold polygon coordinates
  always_ff @(posedge clk_i) begin
    if (advance) begin
      hx_q   <= pt_x;
      hy_q   <= pt_y;
      fx_q   <= f_x;
      fy_q   <= f_y;
      pvx_q  <= vx_q;
      pvy_q  <= vy_q;
      minx_q <= minx_d;
      maxx_q <= maxx_d;
      miny_q <= miny_d;
      maxy_q <= maxy_d;
    end
  end

  // Result register: load on a closing vertex, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      inside_q <= in_box && par_fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataBits-1){1'b0}}, inside_q};

endmodule : point_in_polygon_crossing_test

`default_nettype wire
